// ----- design/nearest_neighbour_pixel_scaler_top_assert.svh -----
// assertion macros for the port level scaler checker
`ifndef NEAREST_NEIGHBOUR_PIXEL_SCALER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOUR_PIXEL_SCALER_TOP_ASSERT_SVH

// clocked check, off while reset is held
`define NNPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define NNPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/nnps_pkg.sv -----
// shared constants and types of the nearest neighbor pixel scaler
`timescale 1ns / 1ps

package nnps_pkg;

    // sizing
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_FACTOR = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int FAC_W      = $clog2(MAX_FACTOR + 1);
    localparam int CNT_W      = $clog2(MAX_FACTOR);

    // fixed field widths
    localparam int PIX_W   = 24;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 2;
    localparam int SF_W    = 4;
    localparam int INW_W   = 12;
    localparam int HGT_W   = 16;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_REDUCE_MODE  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_SCALE_FACTOR = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_IN_WIDTH     = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_IN_HEIGHT    = 2'd3;

    // commands
    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_REPLAY = 1'b1;

    // one accepted item waiting for the emitter
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             use_ram;
        logic [CNT_W-1:0] cnt;
        logic             rend;
        logic [1:0]       pad;
        logic             refd;
    } t_job;

endpackage

// ----- design/nnps_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module nnps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/nearest_neighbour_pixel_scaler_top.sv -----
// nearest neighbor integer pixel scaler: control, line buffer and result emitter
//
// Input channel i_in_valid / o_in_stall carries one command beat: push a pixel
// (blue, green, red) or replay the next pixel of the buffered row. Output
// channel o_out_valid / i_out_stall carries result beats, one per cycle at most.
// Enlarge mode: a push emits the pixel factor times and stores it in the line
// buffer; after a full row, replay beats re-emit that row until it has shown up
// factor times. Reduce mode: a push yields one beat or none (decimation).
// An out-of-place beat gives a single refused result with zero pixel bytes.
// An accepted item waits in the job register; the emitter register then
// shows its first result beat and takes the next item only once the last
// result of the current one is taken. An item has f results in enlarge mode
// (one if refused), one in reduce mode; with f = 1 and i_out_stall low items
// flow one per cycle. The line buffer is one ram, one write and one read port.
// While i_out_stall is high the shown beat holds; one further item is parked in
// a job register and then o_in_stall rises.
// Reset (synchronous, i_rst_n low) returns the registers to their defaults and
// the position counters to zero; the line buffer is not cleared and needs none.
// Any configuration write restarts the image at row 0, column 0.
`timescale 1ns / 1ps

module nearest_neighbour_pixel_scaler_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [7:0]                  i_pix_blue,
    input  logic [7:0]                  i_pix_green,
    input  logic [7:0]                  i_pix_red,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_out_blue,
    output logic [7:0]                  o_out_green,
    output logic [7:0]                  o_out_red,
    output logic                        o_row_end,
    output logic [1:0]                  o_pad_bytes,
    output logic                        o_refused,
    output logic                        o_last_of_run,
    input  logic                        i_cfg_we,
    input  logic [nnps_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [nnps_pkg::CFG_W-1:0]   i_cfg_data
);

    import nnps_pkg::*;

    localparam int CSUM_W = WID_W + 2;
    localparam int RSUM_W = HGT_W + 2;

    // configuration registers
    logic             r_reduce_mode;
    logic [SF_W-1:0]  r_scale_factor;
    logic [INW_W-1:0] r_in_width;
    logic [HGT_W-1:0] r_in_height;

    // position state
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [HGT_W-1:0] r_in_row,  n_in_row;
    logic [CNT_W-1:0] r_replays, n_replays;
    logic [COL_W-1:0] r_rep_col, n_rep_col;
    logic [CNT_W-1:0] r_col_ph,  n_col_ph;
    logic [1:0]       r_col_q,   n_col_q;
    logic [CNT_W-1:0] r_row_ph,  n_row_ph;

    // job stage
    logic             r_j_valid;
    logic             r_j_fresh;
    t_job             r_job;
    t_job             n_job;
    logic             job_has;

    // emitter
    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_pix;
    logic             r_o_rend;
    logic [1:0]       r_o_pad;
    logic             r_o_ref;
    logic             r_o_last;
    logic [CNT_W-1:0] r_rem;
    logic             r_e_rend;
    logic [1:0]       r_e_pad;

    // effective settings and helpers
    logic [FAC_W-1:0] eff_f;
    logic [WID_W-1:0] eff_w;
    logic [HGT_W-1:0] eff_h;
    logic [CNT_W-1:0] f_m1;
    logic             col_last, rep_last, rep_in, row_last;
    logic             col_ph_last, row_ph_last;
    logic             col_fit, row_fit, col_rend, keep;
    logic [1:0]       red_pad, enl_pad;
    logic             col_adv, row_adv;
    logic             in_acc, emit_free, job_take;
    logic [PIX_W-1:0] in_pix, j_pix, ram_rdata;
    logic             ram_we;

    // clamp the registers to their working range
    always_comb begin
        if (r_scale_factor == '0) begin
            eff_f = FAC_W'(1);
        end else if (32'(r_scale_factor) > 32'(MAX_FACTOR)) begin
            eff_f = FAC_W'(MAX_FACTOR);
        end else begin
            eff_f = FAC_W'(r_scale_factor);
        end
        if (r_in_width == '0) begin
            eff_w = WID_W'(1);
        end else if (32'(r_in_width) > 32'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(r_in_width);
        end
        eff_h = (r_in_height == '0) ? HGT_W'(1) : r_in_height;
    end

    assign f_m1 = CNT_W'(eff_f - FAC_W'(1));

    // position tests
    assign col_last    = (WID_W'(r_in_col) == eff_w - WID_W'(1));
    assign rep_last    = (WID_W'(r_rep_col) == eff_w - WID_W'(1));
    assign rep_in      = (WID_W'(r_rep_col) < eff_w);
    assign row_last    = (r_in_row == eff_h - HGT_W'(1));
    assign col_ph_last = (r_col_ph == f_m1);
    assign row_ph_last = (r_row_ph == f_m1);

    // decimation: column fits if col + f <= width, ends the row if col + 2f > width
    assign col_fit  = (CSUM_W'(r_in_col) + CSUM_W'(eff_f) <= CSUM_W'(eff_w));
    assign row_fit  = (RSUM_W'(r_in_row) + RSUM_W'(eff_f) <= RSUM_W'(eff_h));
    assign col_rend = col_fit
                    && (CSUM_W'(r_in_col) + (CSUM_W'(eff_f) << 1) > CSUM_W'(eff_w));
    assign keep     = (r_col_ph == '0) && (r_row_ph == '0) && col_fit && row_fit;

    // pad count equals output width mod 4 for 3-byte pixels
    assign red_pad = r_col_q + 2'd1;
    assign enl_pad = 2'(eff_w[1:0] * eff_f[1:0]);

    assign in_pix = {i_pix_red, i_pix_green, i_pix_blue};

    // handshakes
    assign emit_free  = !r_o_valid || (!i_out_stall && (r_rem == '0));
    assign job_take   = r_j_valid && emit_free;
    assign o_in_stall = r_j_valid && !job_take;
    assign in_acc     = i_in_valid && !o_in_stall;

    // item decode and next position state
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_replays = r_replays;
        n_rep_col = r_rep_col;
        n_col_ph  = r_col_ph;
        n_col_q   = r_col_q;
        n_row_ph  = r_row_ph;
        n_job     = '0;
        job_has   = 1'b0;
        ram_we    = 1'b0;
        col_adv   = 1'b0;
        row_adv   = 1'b0;

        if (i_cfg_we) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_replays = '0;
            n_rep_col = '0;
            n_col_ph  = '0;
            n_col_q   = '0;
            n_row_ph  = '0;
        end else if (in_acc) begin
            job_has = 1'b1;
            if (r_reduce_mode) begin
                if (i_command == CMD_REPLAY) begin
                    n_job.refd = 1'b1;
                end else begin
                    job_has    = keep;
                    n_job.pix  = in_pix;
                    n_job.rend = col_rend;
                    n_job.pad  = col_rend ? red_pad : 2'd0;
                    col_adv    = 1'b1;
                    row_adv    = col_last;
                end
            end else if (i_command == CMD_PUSH) begin
                if (r_replays != '0) begin
                    n_job.refd = 1'b1;
                end else begin
                    ram_we     = 1'b1;
                    n_job.pix  = in_pix;
                    n_job.cnt  = f_m1;
                    n_job.rend = col_last;
                    n_job.pad  = col_last ? enl_pad : 2'd0;
                    col_adv    = 1'b1;
                    if (col_last) begin
                        n_rep_col = '0;
                        n_replays = f_m1;
                        row_adv   = (f_m1 == '0);
                    end
                end
            end else begin
                if ((r_replays == '0) || !rep_in) begin
                    n_job.refd = 1'b1;
                end else begin
                    n_job.use_ram = 1'b1;
                    n_job.cnt     = f_m1;
                    n_job.rend    = rep_last;
                    n_job.pad     = rep_last ? enl_pad : 2'd0;
                    n_rep_col     = rep_last ? '0 : r_rep_col + COL_W'(1);
                    if (rep_last) begin
                        n_replays = r_replays - CNT_W'(1);
                        row_adv   = (r_replays == CNT_W'(1));
                    end
                end
            end

            // column step
            if (col_adv) begin
                n_in_col = col_last ? '0 : r_in_col + COL_W'(1);
                n_col_ph = (col_last || col_ph_last) ? '0 : r_col_ph + CNT_W'(1);
                if (col_last) begin
                    n_col_q = '0;
                end else if (col_ph_last) begin
                    n_col_q = r_col_q + 2'd1;
                end
            end

            // row step
            if (row_adv) begin
                n_in_row = row_last ? '0 : r_in_row + HGT_W'(1);
                n_row_ph = (row_last || row_ph_last) ? '0 : r_row_ph + CNT_W'(1);
            end
        end
    end

    // configuration and position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reduce_mode  <= 1'b0;
            r_scale_factor <= SF_W'(1);
            r_in_width     <= INW_W'(1);
            r_in_height    <= HGT_W'(1);
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_replays      <= '0;
            r_rep_col      <= '0;
            r_col_ph       <= '0;
            r_col_q        <= '0;
            r_row_ph       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_REDUCE_MODE:  r_reduce_mode  <= i_cfg_data[0];
                    REG_SCALE_FACTOR: r_scale_factor <= i_cfg_data[SF_W-1:0];
                    REG_IN_WIDTH:     r_in_width     <= i_cfg_data[INW_W-1:0];
                    REG_IN_HEIGHT:    r_in_height    <= i_cfg_data[HGT_W-1:0];
                    default: ;
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_replays <= n_replays;
            r_rep_col <= n_rep_col;
            r_col_ph  <= n_col_ph;
            r_col_q   <= n_col_q;
            r_row_ph  <= n_row_ph;
        end
    end

    // line buffer: push writes its column, replay reads the replay column
    nnps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_in_col),
        .i_wdata (in_pix),
        .i_raddr (r_rep_col),
        .o_rdata (ram_rdata)
    );

    // ram data is only valid the cycle after the read
    assign j_pix = (r_j_fresh && r_job.use_ram) ? ram_rdata : r_job.pix;

    // job register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
            r_j_fresh <= 1'b0;
        end else begin
            r_j_fresh <= in_acc && job_has;
            if (in_acc) begin
                r_j_valid <= job_has;
                r_job     <= n_job;
            end else if (job_take) begin
                r_j_valid <= 1'b0;
            end else if (r_j_fresh) begin
                r_job.pix <= j_pix;
            end
        end
    end

    // emitter: one result beat per cycle while i_out_stall is low, repeated for the item's run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_rem     <= '0;
        end else if (job_take) begin
            r_o_valid <= 1'b1;
            r_o_pix   <= j_pix;
            r_rem     <= r_job.cnt;
            r_e_rend  <= r_job.rend;
            r_e_pad   <= r_job.pad;
            r_o_ref   <= r_job.refd;
            r_o_last  <= (r_job.cnt == '0);
            r_o_rend  <= (r_job.cnt == '0) && r_job.rend;
            r_o_pad   <= (r_job.cnt == '0) ? r_job.pad : 2'd0;
        end else if (r_o_valid && !i_out_stall) begin
            if (r_rem == '0) begin
                r_o_valid <= 1'b0;
            end else begin
                r_rem    <= r_rem - CNT_W'(1);
                r_o_last <= (r_rem == CNT_W'(1));
                r_o_rend <= (r_rem == CNT_W'(1)) && r_e_rend;
                r_o_pad  <= (r_rem == CNT_W'(1)) ? r_e_pad : 2'd0;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_blue    = r_o_pix[7:0];
    assign o_out_green   = r_o_pix[15:8];
    assign o_out_red     = r_o_pix[23:16];
    assign o_row_end     = r_o_rend;
    assign o_pad_bytes   = r_o_pad;
    assign o_refused     = r_o_ref;
    assign o_last_of_run = r_o_last;

endmodule

// ----- design/nnps_checker.sv -----
// port level checker for the scaler and its bind
`timescale 1ns / 1ps
`include "nearest_neighbour_pixel_scaler_top_assert.svh"

module nnps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_blue,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_red,
    input logic       o_row_end,
    input logic [1:0] o_pad_bytes,
    input logic       o_refused,
    input logic       o_last_of_run
);

    logic        out_held;
    logic [23:0] out_pix;
    logic [28:0] out_beat;
    logic        refused_ok;

    // views of the result beat
    assign out_held   = o_out_valid && i_out_stall;
    assign out_pix    = {o_out_red, o_out_green, o_out_blue};
    assign out_beat   = {out_pix, o_row_end, o_pad_bytes, o_refused, o_last_of_run};
    assign refused_ok = (out_pix == 24'd0) && !o_row_end && o_last_of_run;

    // a stalled result beat stays up
    `NNPS_ASSERT(a_out_hold, out_held |=> o_out_valid, "result beat dropped")

    // a stalled result beat keeps its payload
    `NNPS_ASSERT(a_out_stable, out_held |=> $stable(out_beat), "stalled beat changed")

    // refused beat is a lone, empty result
    `NNPS_ASSERT(a_refused_empty, o_out_valid && o_refused |-> refused_ok, "bad refused beat")

    // row end only closes a run
    `NNPS_ASSERT(a_rend_last, o_out_valid && o_row_end |-> o_last_of_run, "row end inside a run")

    // pad bytes only at row end
    `NNPS_ASSERT(a_pad_rend, o_out_valid && o_pad_bytes != 2'd0 |-> o_row_end, "pad outside row end")

endmodule

bind nearest_neighbour_pixel_scaler_top nnps_checker u_nnps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_blue    (o_out_blue),
    .o_out_green   (o_out_green),
    .o_out_red     (o_out_red),
    .o_row_end     (o_row_end),
    .o_pad_bytes   (o_pad_bytes),
    .o_refused     (o_refused),
    .o_last_of_run (o_last_of_run)
);

// ----- verif/scaled_pixel_checker.sv -----
// checker for the pixel scaler: predicts result beats from accepted beats and compares them
`timescale 1ns / 1ps

import nnps_pkg::*;

module scaled_pixel_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_command,
    input  logic [7:0]         i_pix_blue,
    input  logic [7:0]         i_pix_green,
    input  logic [7:0]         i_pix_red,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [7:0]         i_out_blue,
    input  logic [7:0]         i_out_green,
    input  logic [7:0]         i_out_red,
    input  logic               i_row_end,
    input  logic [1:0]         i_pad_bytes,
    input  logic               i_refused,
    input  logic               i_last_of_run,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_beats_checked
);

    // one predicted result beat
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic [1:0] pad;
        logic       refused;
        logic       last;
    } t_scaled_pix;

    t_scaled_pix scaled_q[$];

    // register copy
    logic             cfg_reduce;
    logic [SF_W-1:0]  cfg_factor;
    logic [INW_W-1:0] cfg_width;
    logic [HGT_W-1:0] cfg_height;

    // image position and line buffer
    logic [PIX_W-1:0] line_buf [0:MAX_WIDTH-1];
    logic [11:0]      col;
    logic [15:0]      row;
    logic [2:0]       reps_left;
    logic [11:0]      rep_col;

    int mismatches = 0;
    int checked = 0;

    function automatic int factor_now();
        if (cfg_factor == 0) return 1;
        if (cfg_factor > MAX_FACTOR) return MAX_FACTOR;
        return int'(cfg_factor);
    endfunction

    function automatic int width_now();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    function automatic int height_now();
        return (cfg_height == 0) ? 1 : int'(cfg_height);
    endfunction

    // zero bytes that bring a 24-bit row to a multiple of 4 bytes
    function automatic logic [1:0] row_pad(int out_w);
        int p;
        p = (4 - (out_w * 3) % 4) % 4;
        return p[1:0];
    endfunction

    task automatic queue_beat(logic [23:0] pix, logic rend, logic [1:0] pad, logic refd,
                              logic last);
        t_scaled_pix b;
        b.blue    = pix[7:0];
        b.green   = pix[15:8];
        b.red     = pix[23:16];
        b.row_end = rend;
        b.pad     = pad;
        b.refused = refd;
        b.last    = last;
        scaled_q.push_back(b);
    endtask

    // one pixel repeated factor times, row end only on the final copy
    task automatic queue_copies(logic [23:0] pix, int column, int f, int w);
        logic rend;
        logic fin;
        rend = (column == w - 1);
        for (int k = 0; k < f; k++) begin
            fin = (k == f - 1);
            queue_beat(pix, fin && rend, (fin && rend) ? row_pad(w * f) : 2'd0, 1'b0, fin);
        end
    endtask

    task automatic advance_row();
        int r;
        r = int'(row) + 1;
        if (r >= height_now()) r = 0;
        row = r[15:0];
    endtask

    task automatic restart_image();
        col       = '0;
        row       = '0;
        reps_left = '0;
        rep_col   = '0;
    endtask

    // expected results of one accepted beat
    task automatic scale_item(logic cmd, logic [23:0] pix);
        int  f, w, h, ow, oh, c, r, t;
        logic keep, rend;
        f = factor_now();
        w = width_now();
        h = height_now();
        if (int'(col) >= w) col = '0;
        if (int'(row) >= h) row = '0;
        c = int'(col);
        r = int'(row);
        if (cfg_reduce) begin
            ow = w / f;
            oh = h / f;
            if (cmd == CMD_REPLAY) begin
                queue_beat('0, 1'b0, 2'd0, 1'b1, 1'b1);
            end else begin
                keep = (r % f == 0) && (c % f == 0) && (c / f < ow) && (r / f < oh);
                if (keep) begin
                    rend = (c / f == ow - 1);
                    queue_beat(pix, rend, rend ? row_pad(ow) : 2'd0, 1'b0, 1'b1);
                end
                t = c + 1;
                if (t >= w) begin
                    t = 0;
                    advance_row();
                end
                col = t[11:0];
            end
        end else if (cmd == CMD_PUSH) begin
            if (reps_left != 0) begin
                queue_beat('0, 1'b0, 2'd0, 1'b1, 1'b1);
            end else begin
                line_buf[c] = pix;
                queue_copies(pix, c, f, w);
                t = c + 1;
                if (t >= w) begin
                    t = 0;
                    rep_col = '0;
                    reps_left = 3'(f - 1);
                    if (reps_left == 0) advance_row();
                end
                col = t[11:0];
            end
        end else begin
            if (reps_left == 0 || int'(rep_col) >= w) begin
                queue_beat('0, 1'b0, 2'd0, 1'b1, 1'b1);
            end else begin
                queue_copies(line_buf[rep_col], int'(rep_col), f, w);
                t = int'(rep_col) + 1;
                if (t >= w) begin
                    t = 0;
                    reps_left = reps_left - 3'd1;
                    if (reps_left == 0) advance_row();
                end
                rep_col = t[11:0];
            end
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_scaled_pix exp_b;
        if (!i_rst_n) begin
            cfg_reduce = 1'b0;
            cfg_factor = 4'd1;
            cfg_width  = 12'd1;
            cfg_height = 16'd1;
            restart_image();
            scaled_q.delete();
        end else begin
            // result beat against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (scaled_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected: b %0d g %0d r %0d refused %0d",
                             $time, i_out_blue, i_out_green, i_out_red, i_refused);
                end else begin
                    exp_b = scaled_q.pop_front();
                    check_field("blue", exp_b.blue, i_out_blue);
                    check_field("green", exp_b.green, i_out_green);
                    check_field("red", exp_b.red, i_out_red);
                    check_field("row_end", exp_b.row_end, i_row_end);
                    check_field("pad_bytes", exp_b.pad, i_pad_bytes);
                    check_field("refused", exp_b.refused, i_refused);
                    check_field("last_of_run", exp_b.last, i_last_of_run);
                end
            end
            // register writes restart the image
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_REDUCE_MODE:  cfg_reduce = i_cfg_data[0];
                    REG_SCALE_FACTOR: cfg_factor = i_cfg_data[SF_W-1:0];
                    REG_IN_WIDTH:     cfg_width  = i_cfg_data[INW_W-1:0];
                    REG_IN_HEIGHT:    cfg_height = i_cfg_data[HGT_W-1:0];
                    default: ;
                endcase
                restart_image();
            end
            // accepted command beat
            if (i_in_valid && !i_in_stall) begin
                scale_item(i_command, {i_pix_red, i_pix_green, i_pix_blue});
            end
        end
        o_fail_count    <= mismatches;
        o_pending       <= scaled_q.size();
        o_beats_checked <= checked;
    end

endmodule

// ----- verif/tb.sv -----
// testbench top for the pixel scaler: stimulus, output stalls, watchdog and verdict
`timescale 1ns / 1ps

import nnps_pkg::*;

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BEATS   = 50;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               command = CMD_PUSH;
    logic [7:0]         pix_blue = '0;
    logic [7:0]         pix_green = '0;
    logic [7:0]         pix_red = '0;
    logic               out_stall = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_blue, out_green, out_red;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       refused;
    logic       last_of_run;

    int fail_count, pending, beats_checked;

    // stimulus bookkeeping
    int cur_mode = 0;
    int cur_f = 1;
    int cur_w = 1;
    int burst_left = 0;
    bit calm = 1'b0;
    int beats_sent = 0;
    int settings = 0;
    int hold_req = 0;

    // stall process state
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int hold_seen = 0;
    int quiet = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    nearest_neighbour_pixel_scaler_top u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_pix_blue    (pix_blue),
        .i_pix_green   (pix_green),
        .i_pix_red     (pix_red),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_blue    (out_blue),
        .o_out_green   (out_green),
        .o_out_red     (out_red),
        .o_row_end     (row_end),
        .o_pad_bytes   (pad_bytes),
        .o_refused     (refused),
        .o_last_of_run (last_of_run),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data)
    );

    scaled_pixel_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_command       (command),
        .i_pix_blue      (pix_blue),
        .i_pix_green     (pix_green),
        .i_pix_red       (pix_red),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_blue      (out_blue),
        .i_out_green     (out_green),
        .i_out_red       (out_red),
        .i_row_end       (row_end),
        .i_pad_bytes     (pad_bytes),
        .i_refused       (refused),
        .i_last_of_run   (last_of_run),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    // receiver stalls: a pattern that changes now and then, plus requested long holds
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 150);
        end else begin
            mode_left = mode_left - 1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((mode_left % 8) < 3);
            endcase
        end
    end

    // watchdog on cycles with no beat and no register write
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet <= 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d beats still expected",
                     quiet, pending);
            $display("tb failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [23:0] rand_pix();
        logic [31:0] v;
        v = $urandom();
        return v[23:0];
    endfunction

    function automatic int pick_factor();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(MAX_FACTOR + 1, 15);
        return $urandom_range(1, MAX_FACTOR);
    endfunction

    function automatic int pick_width(int maxw);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(maxw + 1, 12);
        return $urandom_range(1, maxw);
    endfunction

    // hold one beat until it is taken; valid stays up for the caller
    task automatic send_beat(logic cmd, logic [23:0] pix);
        in_valid  <= 1'b1;
        command   <= cmd;
        pix_blue  <= pix[7:0];
        pix_green <= pix[15:8];
        pix_red   <= pix[23:16];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    // sender in bursts with random gaps between them
    task automatic offer(logic cmd, logic [23:0] pix);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_beat(cmd, pix);
    endtask

    // wait until every expected beat came and the block has drained
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int mode, int f, int w, int h);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_REDUCE_MODE;
        cfg_data <= mode[CFG_W-1:0];
        @(posedge clk);
        cfg_addr <= REG_SCALE_FACTOR;
        cfg_data <= f[CFG_W-1:0];
        @(posedge clk);
        cfg_addr <= REG_IN_WIDTH;
        cfg_data <= w[CFG_W-1:0];
        @(posedge clk);
        cfg_addr <= REG_IN_HEIGHT;
        cfg_data <= h[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = mode;
        cur_f = (f == 0) ? 1 : ((f > MAX_FACTOR) ? MAX_FACTOR : f);
        cur_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        settings++;
    endtask

    // well-formed rows (push row, then its replays) with misplaced beats mixed in
    task automatic feed_rows(int rows, int noise_pct);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cur_w; c++) begin
                if ($urandom_range(0, 99) < noise_pct) offer(CMD_REPLAY, rand_pix());
                offer(CMD_PUSH, rand_pix());
            end
            if (cur_mode == 0) begin
                for (int k = 1; k < cur_f; k++) begin
                    for (int c = 0; c < cur_w; c++) begin
                        if ($urandom_range(0, 99) < noise_pct) offer(CMD_PUSH, rand_pix());
                        offer(CMD_REPLAY, rand_pix());
                    end
                end
            end
        end
    endtask

    task automatic noise_beats(int n);
        repeat (n) offer($urandom_range(0, 1) ? CMD_REPLAY : CMD_PUSH, rand_pix());
    endtask

    initial begin
        int start, mode, fac, wid, hgt, rows, tail;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // defaults after reset: factor 1, width 1, replay with nothing pending
        offer(CMD_PUSH, 24'h000000);
        offer(CMD_PUSH, 24'hFFFFFF);
        offer(CMD_REPLAY, 24'hFFFFFF);
        settle();

        // enlarge by 3: push while replays pending, replay past the last one
        configure(0, 3, 2, 1);
        offer(CMD_PUSH, 24'h123456);
        offer(CMD_PUSH, 24'hA5C3F0);
        offer(CMD_PUSH, 24'h5A3C0F);
        repeat (4) offer(CMD_REPLAY, 24'h000000);
        offer(CMD_REPLAY, 24'hFFFFFF);
        settle();

        // factor above the maximum, then restart with replays still pending
        configure(0, 15, 1, 0);
        offer(CMD_PUSH, 24'hFF00FF);
        repeat (2) offer(CMD_REPLAY, 24'h00FF00);
        settle();

        // reduce with zero factor, width and height
        configure(1, 0, 0, 0);
        offer(CMD_PUSH, 24'h0F0F0F);
        offer(CMD_PUSH, 24'hF0F0F0);
        offer(CMD_REPLAY, 24'h777777);
        settle();

        // reduce with width below factor: every pixel dropped
        configure(1, 2, 1, 3);
        repeat (3) offer(CMD_PUSH, rand_pix());
        settle();

        // clamped width and factor, tallest image, start of the widest row
        configure(1, 15, 4095, 65535);
        repeat (8) offer(CMD_PUSH, rand_pix());
        settle();
        configure(0, 1, MAX_WIDTH, 1);
        repeat (4) offer(CMD_PUSH, rand_pix());
        settle();

        // long output hold while the sender keeps offering
        calm = 1'b1;
        configure(0, MAX_FACTOR, 3, 2);
        hold_req <= hold_req + 1;
        feed_rows(1, 0);
        settle();

        // random settings with mostly well-formed rows
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            calm = ($urandom_range(0, 3) == 0);
            mode = ($urandom_range(0, 9) < 6) ? 0 : 1;
            fac  = pick_factor();
            if (mode == 0) begin
                wid = pick_width(6);
                hgt = $urandom_range(0, 65535);
            end else begin
                wid = pick_width(8);
                hgt = $urandom_range(0, 17);
            end
            configure(mode, fac, wid, hgt);
            if (mode == 0) begin
                feed_rows(1, 10);
                // partial row left behind for the next restart
                tail = $urandom_range(0, cur_w);
                repeat (tail) offer(CMD_PUSH, rand_pix());
            end else begin
                rows = ((hgt == 0) ? 1 : hgt) + 1;
                if (rows > 4) rows = 4;
                feed_rows(rows, 10);
            end
            if ($urandom_range(0, 3) == 0) noise_beats($urandom_range(1, 4));
            settle();
        end

        settle();
        $display("covered %0d command beats and %0d result beats over %0d register settings",
                 beats_sent, beats_checked, settings);
        $display("both modes, clamped registers, refusals, dropped pixels and a long hold");
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ----- nearest_neighbour_pixel_scaler_top.f -----
+incdir+design
design/nnps_pkg.sv
design/nnps_ram.sv
design/nearest_neighbour_pixel_scaler_top.sv
design/nnps_checker.sv
verif/scaled_pixel_checker.sv
verif/tb.sv
